// ===== design/psoa_pkg.sv =====
package psoa_pkg;

  localparam int GainFracBits = 8;
  localparam int InDataWidth  = 56;
  localparam int OutDataWidth = 32;
  localparam int QueueDepth   = 4;
  localparam int QueuePtrBits = 2;

  localparam logic [2:0] REG_DEAD_ZONE       = 3'd0;
  localparam logic [2:0] REG_INTEG_LIMIT     = 3'd1;
  localparam logic [2:0] REG_KP_GAIN         = 3'd2;
  localparam logic [2:0] REG_KI_GAIN         = 3'd3;
  localparam logic [2:0] REG_SPEED_LIMIT     = 3'd4;
  localparam logic [2:0] REG_RIGHT_ANGLE     = 3'd5;
  localparam logic [2:0] REG_TILT_LIMIT      = 3'd6;
  localparam logic [2:0] REG_WALL_DISTANCE   = 3'd7;

  typedef enum logic [2:0] {
    ACT_STOP,
    ACT_PI,
    ACT_SIDE_POS,
    ACT_SIDE_NEG,
    ACT_QUARTER,
    ACT_WALL_POS,
    ACT_WALL_NEG
  } act_t;

  typedef struct packed {
    logic [7:0]  dead_zone;
    logic [14:0] integ_limit;
    logic [15:0] kp_gain;
    logic [15:0] ki_gain;
    logic [11:0] speed_limit;
    logic [7:0]  right_angle;
    logic [6:0]  tilt_limit;
    logic [11:0] wall_distance;
  } cfg_t;

  typedef struct packed {
    act_t               act;
    logic               dead;
    logic signed [8:0]  heading_error;
    logic [11:0]        nearest_level;
    logic signed [12:0] sensor_delta;
  } item_t;

endpackage

// ===== design/pi_steering_with_obstacle_avoid_core.sv =====
// Differential-drive PI steering with obstacle avoidance. One beat per control
// tick carries the heading error, the nearest proximity sensor with its level,
// the sensor delta and both tilt angles, with the run-done flag on s_tlast; one
// beat of right and left wheel speeds comes back for each. The block takes one
// beat every cycle unless the queue is full; beats pass the front classifier, a
// four-entry queue and the three-stage back pipeline (integrator and gain
// multipliers, PI scaling and saturation, wheel speed select and clamp). The
// queue absorbs up to four beats while m_tready is low. The user must write
// configuration through cfg_we/cfg_index/cfg_data only while idle, unchecked.
module pi_steering_with_obstacle_avoid_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // heading_error[8:0], nearest_sensor[11:9], nearest_level[23:12],
  // sensor_delta[36:24], tilt_y[44:37], tilt_x[52:45], zero pad
  input  logic [psoa_pkg::InDataWidth-1:0]   s_tdata,
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // right_speed[12:0], left_speed[25:13], zero pad
  output logic [psoa_pkg::OutDataWidth-1:0]  m_tdata,
  input  logic                               cfg_we,
  input  logic [2:0]                         cfg_index,
  input  logic [15:0]                        cfg_data
);
  import psoa_pkg::*;

  cfg_t  cfg;
  item_t front_item;
  item_t q_item;
  logic  q_full;
  logic  q_valid;
  logic  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_zone       <= 8'd2;
      cfg.integ_limit     <= 15'd1100;
      cfg.kp_gain         <= 16'd512;
      cfg.ki_gain         <= 16'd8;
      cfg.speed_limit     <= 12'd1100;
      cfg.right_angle     <= 8'd90;
      cfg.tilt_limit      <= 7'd5;
      cfg.wall_distance   <= 12'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DEAD_ZONE:       cfg.dead_zone       <= cfg_data[7:0];
        REG_INTEG_LIMIT:     cfg.integ_limit     <= cfg_data[14:0];
        REG_KP_GAIN:         cfg.kp_gain         <= cfg_data;
        REG_KI_GAIN:         cfg.ki_gain         <= cfg_data;
        REG_SPEED_LIMIT:     cfg.speed_limit     <= cfg_data[11:0];
        REG_RIGHT_ANGLE:     cfg.right_angle     <= cfg_data[7:0];
        REG_TILT_LIMIT:      cfg.tilt_limit      <= cfg_data[6:0];
        REG_WALL_DISTANCE:   cfg.wall_distance   <= cfg_data[11:0];
        default:             cfg                 <= cfg;
      endcase
    end
  end

  assign s_tready = !q_full;

  psoa_front u_front (
    .cfg     (cfg),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .item    (front_item)
  );

  psoa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .item      (q_item)
  );

  psoa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== design/psoa_front.sv =====
module psoa_front (
  input  psoa_pkg::cfg_t                            cfg,
  input  logic [psoa_pkg::InDataWidth-1:0]          s_tdata,
  input  logic                                      s_tlast,
  output psoa_pkg::item_t                           item
);
  import psoa_pkg::*;

  logic signed [8:0]  e;
  logic [2:0]         s;
  logic [11:0]        lvl;
  logic signed [12:0] d;
  logic [7:0]         ty;
  logic [7:0]         tx;
  logic [8:0]         e_mag;
  logic [7:0]         ty_mag;
  logic [7:0]         tx_mag;
  logic               drive;
  logic               pos;
  logic               neg;
  logic               obst;
  act_t               act;

  assign e   = $signed(s_tdata[8:0]);
  assign s   = s_tdata[11:9];
  assign lvl = s_tdata[23:12];
  assign d   = $signed(s_tdata[36:24]);
  assign ty  = s_tdata[44:37];
  assign tx  = s_tdata[52:45];

  assign e_mag  = e[8] ? (~s_tdata[8:0] + 9'd1) : s_tdata[8:0];
  assign ty_mag = ty[7] ? (~ty + 8'd1) : ty;
  assign tx_mag = tx[7] ? (~tx + 8'd1) : tx;

  assign drive = !s_tlast && ((ty_mag > {1'b0, cfg.tilt_limit}) ||
                              (tx_mag > {1'b0, cfg.tilt_limit}));
  assign pos = !e[8] && (e != 9'sd0) && (e_mag < {1'b0, cfg.right_angle});
  assign neg = (e[8] || (e == 9'sd0)) && (e_mag < {1'b0, cfg.right_angle});

  always_comb begin
    case (s)
      3'd0:    obst = pos && (lvl != 12'd0);
      3'd1,
      3'd2:    obst = pos;
      3'd3,
      3'd4:    obst = 1'b1;
      default: obst = neg;
    endcase
  end

  always_comb begin
    if (!drive) begin
      act = ACT_STOP;
    end else if (!obst) begin
      act = ACT_PI;
    end else begin
      case (s)
        3'd0, 3'd1: act = ACT_SIDE_POS;
        3'd2:       act = ACT_WALL_NEG;
        3'd3, 3'd4: act = ACT_QUARTER;
        3'd5:       act = ACT_WALL_POS;
        default:    act = ACT_SIDE_NEG;
      endcase
    end
  end

  assign item.act           = act;
  assign item.dead          = e_mag < {1'b0, cfg.dead_zone};
  assign item.heading_error = e;
  assign item.nearest_level = lvl;
  assign item.sensor_delta  = d;

endmodule

// ===== design/psoa_queue.sv =====
module psoa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  psoa_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output psoa_pkg::item_t item
);
  import psoa_pkg::*;

  item_t                   mem [QueueDepth];
  logic [QueuePtrBits-1:0] wr_ptr;
  logic [QueuePtrBits-1:0] rd_ptr;
  logic [QueuePtrBits:0]   count;

  assign full  = count == (QueuePtrBits+1)'(QueueDepth);
  assign valid = count != '0;
  assign item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

// ===== design/psoa_back.sv =====
module psoa_back (
  input  logic                               clk,
  input  logic                               rst,
  input  psoa_pkg::cfg_t                     cfg,
  input  logic                               q_valid,
  input  psoa_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [psoa_pkg::OutDataWidth-1:0]  m_tdata
);
  import psoa_pkg::*;

  function automatic logic signed [12:0] clamp_speed(input logic signed [17:0] v,
                                                    input logic [11:0] lim);
    logic signed [17:0] limv;
    limv = $signed({6'b0, lim});
    if (v > limv) begin
      return 13'(limv);
    end else if (v < -limv) begin
      return 13'(-limv);
    end else begin
      return 13'(v);
    end
  endfunction

  logic                adv;
  logic signed [16:0]  integrator;
  logic signed [16:0]  integrator_next;

  logic                a_valid;
  act_t                a_act;
  logic                a_dead;
  logic signed [25:0]  a_pp;
  logic signed [33:0]  a_pi;
  logic signed [14:0]  a_r_obs;
  logic signed [14:0]  a_l_obs;

  logic                b_valid;
  act_t                b_act;
  logic signed [15:0]  b_pi;
  logic [14:0]         b_pi_mag;
  logic signed [14:0]  b_r_obs;
  logic signed [14:0]  b_l_obs;

  logic signed [12:0]  right_speed;
  logic signed [12:0]  left_speed;

  logic signed [17:0]  isum;
  logic signed [17:0]  ilim;
  logic signed [17:0]  iclamp;
  logic signed [16:0]  integ_use;
  logic [11:0]         half;
  logic [11:0]         quarter;
  logic signed [14:0]  half_s;
  logic signed [12:0]  wall;
  logic signed [13:0]  t;
  logic signed [14:0]  r_obs;
  logic signed [14:0]  l_obs;

  logic signed [33:0]  acc;
  logic [33:0]         acc_abs;
  logic [33:0]         mag_full;
  logic [14:0]         pi_mag;
  logic signed [15:0]  pi_val;

  logic signed [16:0]  base;
  logic signed [17:0]  rs;
  logic signed [17:0]  ls;
  logic signed [17:0]  rh;
  logic signed [17:0]  lh;
  logic signed [17:0]  r_sel;
  logic signed [17:0]  l_sel;

  assign adv   = !m_tvalid || m_tready;
  assign q_pop = adv && q_valid;

  // integrator and products
  assign isum   = 18'(integrator) + 18'(q_item.heading_error);
  assign ilim   = $signed({3'b0, cfg.integ_limit});
  assign iclamp = (isum > ilim) ? ilim : ((isum < -ilim) ? -ilim : isum);
  assign integrator_next = q_item.dead ? integrator : 17'(iclamp);
  assign integ_use = integrator_next;

  assign half    = {1'b0, cfg.speed_limit[11:1]};
  assign quarter = {2'b0, cfg.speed_limit[11:2]};
  assign half_s  = $signed({3'b0, half});
  assign wall    = $signed({1'b0, q_item.nearest_level}) - $signed({1'b0, cfg.wall_distance});

  always_comb begin
    case (q_item.act)
      ACT_SIDE_POS: t = 14'(q_item.sensor_delta);
      ACT_SIDE_NEG: t = -14'(q_item.sensor_delta);
      ACT_WALL_POS: t = 14'(wall);
      ACT_WALL_NEG: t = -14'(wall);
      default:      t = '0;
    endcase
    if (q_item.act == ACT_QUARTER) begin
      r_obs = $signed({3'b0, quarter});
      l_obs = $signed({3'b0, quarter});
    end else begin
      r_obs = half_s + 15'(t);
      l_obs = half_s - 15'(t);
    end
  end

  // PI term
  assign acc      = 34'(a_pp) + a_pi;
  assign acc_abs  = acc[33] ? 34'(-acc) : 34'(acc);
  assign mag_full = acc_abs >> GainFracBits;
  assign pi_mag   = a_dead ? 15'd0 :
                    ((mag_full > 34'd32767) ? 15'h7fff : mag_full[14:0]);
  assign pi_val   = acc[33] ? -$signed({1'b0, pi_mag}) : $signed({1'b0, pi_mag});

  // wheel speeds
  assign base = $signed({5'b0, cfg.speed_limit}) - $signed({2'b0, b_pi_mag});
  assign rs   = 18'(base) - 18'(b_pi);
  assign ls   = 18'(base) + 18'(b_pi);
  assign rh   = (rs + $signed({17'b0, rs[17]})) >>> 1;
  assign lh   = (ls + $signed({17'b0, ls[17]})) >>> 1;

  always_comb begin
    case (b_act)
      ACT_STOP: begin
        r_sel = '0;
        l_sel = '0;
      end
      ACT_PI: begin
        r_sel = rh;
        l_sel = lh;
      end
      default: begin
        r_sel = 18'(b_r_obs);
        l_sel = 18'(b_l_obs);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integrator <= '0;
      a_valid    <= 1'b0;
      b_valid    <= 1'b0;
      m_tvalid   <= 1'b0;
    end else if (adv) begin
      if (q_valid) begin
        integrator <= integrator_next;
      end
      a_valid  <= q_valid;
      b_valid  <= a_valid;
      m_tvalid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_act       <= q_item.act;
      a_dead      <= q_item.dead;
      a_pp        <= 26'($signed({1'b0, cfg.kp_gain})) * 26'(q_item.heading_error);
      a_pi        <= 34'($signed({1'b0, cfg.ki_gain})) * 34'(integ_use);
      a_r_obs     <= r_obs;
      a_l_obs     <= l_obs;
      b_act       <= a_act;
      b_pi        <= pi_val;
      b_pi_mag    <= pi_mag;
      b_r_obs     <= a_r_obs;
      b_l_obs     <= a_l_obs;
      right_speed <= clamp_speed(r_sel, cfg.speed_limit);
      left_speed  <= clamp_speed(l_sel, cfg.speed_limit);
    end
  end

  assign m_tdata = {6'b0, left_speed, right_speed};

endmodule

// ===== design/psoa_checker.sv =====
module psoa_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               m_tvalid,
  input logic                               m_tready,
  input logic [psoa_pkg::OutDataWidth-1:0]  m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output beat changed");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[12:0] != 13'h1000) && (m_tdata[25:13] != 13'h1000))
    else $error("wheel speed outside clamp range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[31:26] == 6'd0)
    else $error("output pad bits not zero");

endmodule

bind pi_steering_with_obstacle_avoid_core psoa_checker u_psoa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/pi_steering_with_obstacle_avoid_core_tb.sv =====
module pi_steering_with_obstacle_avoid_core_tb;
  import psoa_pkg::*;

  localparam int QuietLimit = 2000;

  typedef struct {
    logic signed [8:0]  heading_error;
    logic [2:0]         nearest_sensor;
    logic [11:0]        nearest_level;
    logic signed [12:0] sensor_delta;
    logic signed [7:0]  tilt_y;
    logic signed [7:0]  tilt_x;
    logic               finished;
  } tick_t;

  typedef struct {
    logic [12:0] right_speed;
    logic [12:0] left_speed;
  } speeds_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic                    s_tlast = 1'b0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b1;
  logic [OutDataWidth-1:0] m_tdata;
  logic                    cfg_we = 1'b0;
  logic [2:0]              cfg_index = REG_DEAD_ZONE;
  logic [15:0]             cfg_data = '0;

  cfg_t    cfg;
  int      integ;
  speeds_t pending_speeds[$];
  int      mismatches = 0;
  bit      idling = 1'b1;
  int      sink_hold = 0;
  int      quiet_cycles = 0;

  pi_steering_with_obstacle_avoid_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int iabs(int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic cfg_t reset_cfg();
    cfg_t c;
    c.dead_zone       = 8'd2;
    c.integ_limit     = 15'd1100;
    c.kp_gain         = 16'd512;
    c.ki_gain         = 16'd8;
    c.speed_limit     = 12'd1100;
    c.right_angle     = 8'd90;
    c.tilt_limit      = 7'd5;
    c.wall_distance   = 12'd200;
    return c;
  endfunction

  function automatic cfg_t rand_cfg();
    cfg_t c;
    c.dead_zone       = 8'($urandom_range(0, 180));
    c.integ_limit     = 15'($urandom_range(0, 32767));
    c.kp_gain         = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1023));
    c.ki_gain         = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 255));
    c.speed_limit     = 12'($urandom_range(0, 2200));
    c.right_angle     = 8'($urandom_range(0, 180));
    c.tilt_limit      = 7'($urandom_range(0, 90));
    c.wall_distance   = 12'($urandom);
    return c;
  endfunction

  // PI regulator, tilt gating, per-sensor obstacle rule and clamp for one tick
  function automatic speeds_t steer_predict(tick_t t);
    int      e, s, lvl, d, lim, half, quarter, wall, ra, tl, thr, sum_lim;
    int      pi_val, base, r, l;
    longint  acc, mag;
    bit      toward_pos, toward_neg, blocked;
    speeds_t sp;
    e       = t.heading_error;
    s       = t.nearest_sensor;
    lvl     = t.nearest_level;
    d       = t.sensor_delta;
    lim     = cfg.speed_limit;
    half    = lim / 2;
    quarter = lim / 4;
    wall    = lvl - int'(cfg.wall_distance);
    ra      = cfg.right_angle;
    tl      = cfg.tilt_limit;
    thr     = cfg.dead_zone;
    sum_lim = cfg.integ_limit;
    pi_val  = 0;
    if (iabs(e) >= thr) begin
      integ = integ + e;
      if (integ > sum_lim) integ = sum_lim;
      else if (integ < -sum_lim) integ = -sum_lim;
      acc = longint'(cfg.kp_gain) * e + longint'(cfg.ki_gain) * integ;
      mag = ((acc < 0) ? -acc : acc) >> GainFracBits;
      if (mag > 32767) mag = 32767;
      pi_val = (acc < 0) ? -int'(mag) : int'(mag);
    end
    base = lim - iabs(pi_val);
    r = 0;
    l = 0;
    if (!t.finished && (iabs(int'(t.tilt_y)) > tl || iabs(int'(t.tilt_x)) > tl)) begin
      toward_pos = (e > 0) && (e < ra);
      toward_neg = (e <= 0) && (e > -ra);
      blocked = (s == 3 || s == 4) ||
                (((s == 0 && lvl != 0) || s == 1 || s == 2) && toward_pos) ||
                (s >= 5 && toward_neg);
      if (blocked) begin
        case (s)
          0, 1: begin r = half + d; l = half - d; end
          6, 7: begin r = half - d; l = half + d; end
          3, 4: begin r = quarter; l = quarter; end
          2: begin r = half - wall; l = half + wall; end
          default: begin r = half + wall; l = half - wall; end
        endcase
      end else begin
        r = (base - pi_val) / 2;
        l = (base + pi_val) / 2;
      end
      if (r > lim) r = lim;
      else if (r < -lim) r = -lim;
      if (l > lim) l = lim;
      else if (l < -lim) l = -lim;
    end
    sp.right_speed = r[12:0];
    sp.left_speed  = l[12:0];
    return sp;
  endfunction

  function automatic tick_t mk_tick(int he, int s, int lvl, int d, int ty, int tx, bit fin);
    tick_t t;
    t.heading_error  = 9'(he);
    t.nearest_sensor = 3'(s);
    t.nearest_level  = 12'(lvl);
    t.sensor_delta   = 13'(d);
    t.tilt_y         = 8'(ty);
    t.tilt_x         = 8'(tx);
    t.finished       = fin;
    return t;
  endfunction

  function automatic tick_t rand_tick();
    tick_t t;
    int    ra, thr, tl;
    ra  = cfg.right_angle;
    thr = cfg.dead_zone;
    tl  = cfg.tilt_limit;
    case ($urandom_range(0, 9))
      0: t.heading_error = 9'($urandom);
      1: t.heading_error = 9'($urandom_range(0, 1) ? ra - int'($urandom_range(0, 1))
                                                    : -ra + int'($urandom_range(0, 1)));
      2: t.heading_error = 9'($urandom_range(0, 1) ? thr - int'($urandom_range(0, 1))
                                                    : -thr + int'($urandom_range(0, 1)));
      default: t.heading_error = 9'(int'($urandom_range(0, 360)) - 180);
    endcase
    t.nearest_sensor = 3'($urandom_range(0, 7));
    t.nearest_level  = ($urandom_range(0, 7) == 0) ? 12'd0 : 12'($urandom);
    t.sensor_delta   = ($urandom_range(0, 7) == 0) ? 13'($urandom)
                                                   : 13'(int'($urandom_range(0, 8190)) - 4095);
    case ($urandom_range(0, 7))
      0: begin
        t.tilt_y = 8'($urandom);
        t.tilt_x = 8'($urandom);
      end
      1: begin
        t.tilt_y = 8'(int'($urandom_range(0, 2 * tl)) - tl);
        t.tilt_x = 8'(int'($urandom_range(0, 2 * tl)) - tl);
      end
      default: begin
        t.tilt_y = 8'(int'($urandom_range(0, 180)) - 90);
        t.tilt_x = 8'(int'($urandom_range(0, 180)) - 90);
      end
    endcase
    t.finished = ($urandom_range(0, 9) == 0);
    return t;
  endfunction

  task automatic push_tick(tick_t t);
    if (idling && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tlast  <= t.finished;
    s_tdata  <= {3'b000, t.tilt_x, t.tilt_y, t.sensor_delta, t.nearest_level,
                 t.nearest_sensor, t.heading_error};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_speeds.push_back(steer_predict(t));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic load_config(cfg_t c);
    write_reg(REG_DEAD_ZONE,       16'(c.dead_zone));
    write_reg(REG_INTEG_LIMIT,     16'(c.integ_limit));
    write_reg(REG_KP_GAIN,         c.kp_gain);
    write_reg(REG_KI_GAIN,         c.ki_gain);
    write_reg(REG_SPEED_LIMIT,     16'(c.speed_limit));
    write_reg(REG_RIGHT_ANGLE,     16'(c.right_angle));
    write_reg(REG_TILT_LIMIT,      16'(c.tilt_limit));
    write_reg(REG_WALL_DISTANCE,   16'(c.wall_distance));
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg = c;
  endtask

  task automatic test_sensor_rules();
    for (int s = 0; s < 8; s++) push_tick(mk_tick(30, s, 900, 150, 20, 0, 1'b0));
    for (int s = 0; s < 8; s++) push_tick(mk_tick(-30, s, 100, -150, 0, -20, 1'b0));
    push_tick(mk_tick(30, 0, 0, 150, 20, 0, 1'b0));
    push_tick(mk_tick(90, 1, 500, 80, 20, 0, 1'b0));
    push_tick(mk_tick(-90, 7, 500, 80, 20, 0, 1'b0));
    push_tick(mk_tick(0, 6, 500, -80, 20, 0, 1'b0));
    drain();
  endtask

  task automatic test_drive_gating();
    push_tick(mk_tick(40, 1, 700, 60, 30, 30, 1'b1));
    push_tick(mk_tick(40, 3, 700, 60, 5, -5, 1'b0));
    push_tick(mk_tick(1, 4, 700, 60, 0, -6, 1'b0));
    push_tick(mk_tick(2, 5, 700, 60, -128, 127, 1'b0));
    drain();
  endtask

  task automatic test_field_extremes();
    push_tick(mk_tick(-256, 7, 4095, 4095, 127, 0, 1'b0));
    push_tick(mk_tick(255, 2, 4095, -4096, -128, 0, 1'b0));
    push_tick(mk_tick(-1, 0, 0, -4096, 90, -90, 1'b0));
    drain();
  endtask

  task automatic test_config_sweep();
    cfg_t c;
    for (int k = 0; k < 5; k++) begin
      c = rand_cfg();
      case (k)
        1: c = '0;
        2: begin
          c.dead_zone       = 8'd180;
          c.integ_limit     = 15'd32767;
          c.kp_gain         = 16'hFFFF;
          c.ki_gain         = 16'hFFFF;
          c.speed_limit     = 12'd2200;
          c.right_angle     = 8'd180;
          c.tilt_limit      = 7'd90;
          c.wall_distance   = 12'd4095;
        end
        3: c = '1;
        default: ;
      endcase
      load_config(c);
      idling = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 100; n++) push_tick(rand_tick());
      drain();
    end
  endtask

  task automatic test_back_to_back();
    load_config(reset_cfg());
    idling = 1'b0;
    for (int n = 0; n < 80; n++) push_tick(rand_tick());
    drain();
  endtask

  function automatic void note_mismatch(string what, logic [12:0] want, logic [12:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d got %0d", what, $signed(want), $signed(got));
  endfunction

  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold--;
      m_tready <= 1'b0;
    end else if (idling && $urandom_range(0, 9) == 0) begin
      sink_hold = $urandom_range(0, 16);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    speeds_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_speeds.size() == 0) begin
        note_mismatch("unexpected beat, right_speed", '0, m_tdata[12:0]);
      end else begin
        want = pending_speeds.pop_front();
        if (m_tdata[12:0] !== want.right_speed)
          note_mismatch("right_speed", want.right_speed, m_tdata[12:0]);
        if (m_tdata[25:13] !== want.left_speed)
          note_mismatch("left_speed", want.left_speed, m_tdata[25:13]);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (!s_tvalid && pending_speeds.size() == 0))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QuietLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    cfg   = reset_cfg();
    integ = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_sensor_rules();
    test_drive_gating();
    test_field_extremes();
    test_config_sweep();
    test_back_to_back();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_speeds.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
